[hdl/ffra_pkg.sv]
// Shared types, constants and tables for the first-fit allocator.
// Used by the controller, the datapath and the top level.
package ffra_pkg;

    localparam int BLOCK_SLOTS  = 16;
    localparam int SIZE_BITS    = 20;
    localparam int ID_BITS      = 16;
    localparam int REGION_SLOTS = BLOCK_SLOTS + 1;
    localparam int SLOT_W       = $clog2(BLOCK_SLOTS);
    localparam int REG_W        = $clog2(REGION_SLOTS);
    localparam int RCNT_W       = $clog2(REGION_SLOTS + 1);
    localparam int LIVE_W       = $clog2(BLOCK_SLOTS + 1);
    localparam int FIELD_W      = 21;
    localparam int F_ID_W       = 16;
    localparam int F_LIVE_W     = 5;
    localparam int SZ_W         = SIZE_BITS + 1;
    localparam int NID_W        = ID_BITS + 1;
    localparam logic [SZ_W-1:0] POOL_MAX = SZ_W'(1) << SIZE_BITS;
    localparam logic [15:0] REFS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_INC    = 2'd1,
        FN_DEC    = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BELOW_MIN = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_FULL      = 3'd4,
        ST_IDS_OUT   = 3'd5
    } t_status;

    localparam logic [0:0] REG_MEMORY_SIZE = 1'b0;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,     // capture request, clear scan pointers
        CMD_SLOT_STEP, // examine slot[ptr]
        CMD_REG_STEP,  // examine region[ptr]
        CMD_ALLOC,     // commit create into slot and region
        CMD_SHIFT_DN,  // region[ptr] = region[ptr+1]
        CMD_SHIFT_UP,  // region[ptr] = region[ptr-1]
        CMD_REL_DEC,   // decide release placement
        CMD_REFS,      // apply inc/dec to found slot
        CMD_INSERT,    // write freed region at p
        CMD_RESULT     // load output register
    } t_cmd;

    typedef struct packed {
        logic slot_done;   // scan over slots finished
        logic slot_hit;    // match / free slot found
        logic reg_done;
        logic reg_hit;
        logic shift_done;
        logic freed;       // dec reached zero
        logic [1:0] rel_kind; // 0 none 1 merge prev 2 merge next 3 insert
        logic rel_merge2;  // prev merge also swallows next
    } t_stat;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    function automatic logic [3:0] type_min(input logic [2:0] t);
        logic [3:0] m;
        unique case (t)
            3'd0:    m = 4'd0;
            3'd2:    m = 4'd8;
            3'd1, 3'd3, 3'd4: m = 4'd4;
            default: m = 4'd1;
        endcase
        return m;
    endfunction

endpackage

[hdl/ffra_ctrl.sv]
// Sequencer for the allocator: walks slot table and free list by steps.
// Depends on ffra_pkg; drives the datapath with commands only.
module ffra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_func,
    input  logic            i_pre_fail, // below min or ids exhausted
    input  logic            i_out_free,
    input  ffra_pkg::t_stat i_stat,
    output ffra_pkg::t_ctl  o_ctl,
    output logic            o_busy
);
    import ffra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_REG, S_ALLOC, S_SHDN, S_REFS, S_RELP,
        S_RELD, S_SHUP, S_INS, S_RES
    } t_state;

    t_state r_state, n_state;
    logic   r_create, n_create;

    always_comb begin
        n_state = r_state;
        n_create = r_create;
        o_ctl.cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                o_ctl.cmd = CMD_LATCH;
                n_create = (i_func == FN_CREATE);
                if (i_func == FN_NONE || (i_func == FN_CREATE && i_pre_fail))
                    n_state = S_RES;
                else
                    n_state = S_SLOT;
            end
            S_SLOT: begin
                o_ctl.cmd = CMD_SLOT_STEP;
                if (i_stat.slot_hit)
                    n_state = r_create ? S_REG : S_REFS;
                else if (i_stat.slot_done)
                    n_state = S_RES;
            end
            S_REG: begin
                o_ctl.cmd = CMD_REG_STEP;
                if (i_stat.reg_hit)
                    n_state = S_ALLOC;
                else if (i_stat.reg_done)
                    n_state = S_RES;
            end
            S_ALLOC: begin
                o_ctl.cmd = CMD_ALLOC;
                n_state = i_stat.shift_done ? S_RES : S_SHDN;
            end
            S_SHDN: begin
                o_ctl.cmd = CMD_SHIFT_DN;
                if (i_stat.shift_done)
                    n_state = S_RES;
            end
            S_REFS: begin
                o_ctl.cmd = CMD_REFS;
                n_state = i_stat.freed ? S_RELP : S_RES;
            end
            S_RELP: begin
                // find first region at or above the freed offset
                o_ctl.cmd = CMD_REG_STEP;
                if (i_stat.reg_hit || i_stat.reg_done)
                    n_state = S_RELD;
            end
            S_RELD: begin
                o_ctl.cmd = CMD_REL_DEC;
                unique case (i_stat.rel_kind)
                    2'd0:    n_state = S_RES;
                    2'd1:    n_state = i_stat.rel_merge2 ? S_SHDN : S_RES;
                    2'd2:    n_state = S_RES;
                    default: n_state = S_SHUP;
                endcase
            end
            S_SHUP: begin
                o_ctl.cmd = CMD_SHIFT_UP;
                if (i_stat.shift_done)
                    n_state = S_INS;
            end
            S_INS: begin
                o_ctl.cmd = CMD_INSERT;
                n_state = S_RES;
            end
            S_RES: if (i_out_free) begin
                o_ctl.cmd = CMD_RESULT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_create <= 1'b0;
        end else begin
            r_state <= n_state;
            r_create <= n_create;
        end
    end
endmodule

[hdl/ffra_dp.sv]
// Datapath: slot table, free-region list, counters and result register.
// Depends on ffra_pkg; obeys commands from ffra_ctrl.
module ffra_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ffra_pkg::t_ctl          i_ctl,
    output ffra_pkg::t_stat         o_stat,
    input  logic                    i_cfg_we,
    input  logic [ffra_pkg::FIELD_W-1:0] i_cfg_data,
    output logic [ffra_pkg::FIELD_W-1:0] o_mem_size,
    input  logic [1:0]              i_func,
    input  logic [ffra_pkg::FIELD_W-1:0] i_alloc_size,
    input  logic [2:0]              i_type_code,
    input  logic [15:0]             i_block_id,
    output logic                    o_pre_fail,
    input  logic                    i_out_take,
    output logic                    o_out_valid,
    output logic [2:0]              o_status,
    output logic [15:0]             o_new_id,
    output logic [ffra_pkg::FIELD_W-1:0] o_block_offset,
    output logic [15:0]             o_ref_count,
    output logic                    o_freed,
    output logic [ffra_pkg::FIELD_W-1:0] o_used_bytes,
    output logic [4:0]              o_live_blocks
);
    import ffra_pkg::*;

    logic [SZ_W-1:0]   r_mem_size;
    logic              r_sv [BLOCK_SLOTS];
    logic [ID_BITS-1:0] r_sid [BLOCK_SLOTS];
    logic [SZ_W-1:0]   r_soff [BLOCK_SLOTS];
    logic [SZ_W-1:0]   r_ssz [BLOCK_SLOTS];
    logic [15:0]       r_sref [BLOCK_SLOTS];
    logic [SZ_W-1:0]   r_roff [REGION_SLOTS];
    logic [SZ_W-1:0]   r_rsz [REGION_SLOTS];
    logic [RCNT_W-1:0] r_rcnt;
    logic [NID_W-1:0]  r_next_id;
    logic [SZ_W-1:0]   r_used;
    logic [LIVE_W-1:0] r_live;

    logic [1:0]        r_func;
    logic [SZ_W-1:0]   r_size;
    logic [15:0]       r_id;
    logic [2:0]        r_st;
    logic [SLOT_W:0]   r_sp;   // slot pointer
    logic [RCNT_W-1:0] r_rp;   // region pointer
    logic [RCNT_W-1:0] r_wp;   // shift pointer
    logic [SLOT_W-1:0] r_hs;   // hit slot
    logic [SZ_W-1:0]   r_off;
    logic [15:0]       r_refs;
    logic              r_freed;
    logic [SZ_W-1:0]   r_fsize;

    logic [SZ_W-1:0] w_req;
    assign w_req = (i_alloc_size > POOL_MAX) ? i_alloc_size : i_alloc_size;
    assign o_pre_fail = (i_alloc_size < FIELD_W'(type_min(i_type_code)))
                     || (r_next_id >= (NID_W'(1) << ID_BITS));
    assign o_mem_size = r_mem_size;

    // slot scan
    logic [SLOT_W-1:0] w_si;
    logic              w_slot_hit;
    assign w_si = r_sp[SLOT_W-1:0];
    assign w_slot_hit = (r_sp < (SLOT_W+1)'(BLOCK_SLOTS)) &&
        ((r_func == FN_CREATE) ? !r_sv[w_si]
                               : (r_sv[w_si] && ({{(32-ID_BITS){1'b0}}, r_sid[w_si]}
                                  == {16'd0, r_id})));

    // region scan: create seeks size fit, release seeks offset >= freed
    logic [REG_W-1:0] w_ri, w_wi, w_wi1, w_pm1;
    logic             w_reg_in, w_reg_hit;
    assign w_ri  = r_rp[REG_W-1:0];
    assign w_wi  = r_wp[REG_W-1:0];
    assign w_wi1 = REG_W'(r_wp + 1'b1);
    assign w_pm1 = REG_W'(r_rp - 1'b1);
    assign w_reg_in = r_rp < r_rcnt;
    assign w_reg_hit = w_reg_in && ((r_func == FN_CREATE) ? (r_rsz[w_ri] >= r_size)
                                                          : (r_roff[w_ri] >= r_off));

    // release decision
    logic [SZ_W-1:0] w_pend;
    logic w_mprev, w_mnext, w_m2;
    assign w_pend  = r_roff[w_pm1] + r_rsz[w_pm1];
    assign w_mprev = (r_rp != '0) && (w_pend == r_off);
    assign w_mnext = w_reg_in && ((r_off + r_fsize) == r_roff[w_ri]);
    assign w_m2    = w_mprev && w_reg_in && ((w_pend + r_fsize) == r_roff[w_ri]);

    logic [1:0] w_kind;
    always_comb begin
        priority if (r_fsize == '0)                     w_kind = 2'd0;
        else if (w_mprev)                               w_kind = 2'd1;
        else if (w_mnext)                               w_kind = 2'd2;
        else if (r_rcnt >= RCNT_W'(REGION_SLOTS))       w_kind = 2'd0;
        else                                            w_kind = 2'd3;
    end

    logic [15:0] w_ref_new;
    always_comb begin
        if (r_func == FN_INC)
            w_ref_new = (r_sref[r_hs] < REFS_MAX) ? r_sref[r_hs] + 16'd1 : r_sref[r_hs];
        else
            w_ref_new = (r_sref[r_hs] != 16'd0) ? r_sref[r_hs] - 16'd1 : 16'd0;
    end

    logic w_shift_done;
    always_comb begin
        w_shift_done = 1'b0;
        unique case (i_ctl.cmd)
            CMD_ALLOC:    w_shift_done = (r_rsz[w_ri] != r_size);
            CMD_SHIFT_DN: w_shift_done = (RCNT_W'(r_wp + 1'b1) >= r_rcnt);
            CMD_SHIFT_UP: w_shift_done = (r_wp <= r_rp + 1'b1);
            default:      w_shift_done = 1'b0;
        endcase
    end

    assign o_stat.slot_done  = r_sp >= (SLOT_W+1)'(BLOCK_SLOTS - 1);
    assign o_stat.slot_hit   = w_slot_hit;
    assign o_stat.reg_done   = !w_reg_in || (r_rp + 1'b1 >= r_rcnt);
    assign o_stat.reg_hit    = w_reg_hit;
    assign o_stat.shift_done = w_shift_done;
    assign o_stat.freed      = (r_func == FN_DEC) && (w_ref_new == 16'd0);
    assign o_stat.rel_kind   = w_kind;
    assign o_stat.rel_merge2 = w_m2;

    logic [SZ_W-1:0] w_cfg_sz;
    assign w_cfg_sz = (i_cfg_data > POOL_MAX) ? POOL_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_mem_size <= !i_rst_n ? POOL_MAX : w_cfg_sz;
            for (int k = 0; k < BLOCK_SLOTS; k++) r_sv[k] <= 1'b0;
            r_roff[0] <= '0;
            r_rsz[0]  <= !i_rst_n ? POOL_MAX : w_cfg_sz;
            r_rcnt    <= (!i_rst_n || w_cfg_sz != '0) ? RCNT_W'(1) : '0;
            r_next_id <= NID_W'(1);
            r_used    <= '0;
            r_live    <= '0;
            if (!i_rst_n) o_out_valid <= 1'b0;
        end else begin
            if (i_ctl.cmd == CMD_RESULT) o_out_valid <= 1'b1;
            else if (i_out_take)         o_out_valid <= 1'b0;
            unique case (i_ctl.cmd)
                CMD_LATCH: begin
                    r_func <= i_func; r_size <= w_req; r_id <= i_block_id;
                    r_sp <= '0; r_rp <= '0; r_off <= '0; r_refs <= '0;
                    r_freed <= 1'b0;
                    r_st <= (i_func == FN_CREATE) ? (
                        (i_alloc_size < FIELD_W'(type_min(i_type_code))) ? ST_BELOW_MIN :
                        o_pre_fail ? ST_IDS_OUT : ST_FULL) : ST_NOT_FOUND;
                end
                CMD_SLOT_STEP: begin
                    r_sp <= r_sp + 1'b1;
                    if (w_slot_hit) begin
                        r_hs <= w_si;
                        if (r_func == FN_CREATE) r_st <= ST_NO_SPACE;
                    end
                end
                // stop at the list end so an empty list leaves the pointer at zero
                CMD_REG_STEP: if (w_reg_in && !w_reg_hit) r_rp <= r_rp + 1'b1;
                CMD_ALLOC: begin
                    r_off <= r_roff[w_ri];
                    r_roff[w_ri] <= r_roff[w_ri] + r_size;
                    r_rsz[w_ri]  <= r_rsz[w_ri] - r_size;
                    if (r_rsz[w_ri] == r_size) r_rcnt <= r_rcnt - 1'b1;
                    r_wp <= r_rp;
                    r_sv[r_hs] <= 1'b1; r_sid[r_hs] <= r_next_id[ID_BITS-1:0];
                    r_soff[r_hs] <= r_roff[w_ri]; r_ssz[r_hs] <= r_size;
                    r_sref[r_hs] <= 16'd1;
                    r_next_id <= r_next_id + 1'b1;
                    r_used <= r_used + r_size;
                    r_live <= r_live + 1'b1;
                    r_refs <= 16'd1; r_st <= ST_OK;
                end
                CMD_SHIFT_DN: begin
                    r_roff[w_wi] <= r_roff[w_wi1];
                    r_rsz[w_wi]  <= r_rsz[w_wi1];
                    r_wp <= r_wp + 1'b1;
                end
                CMD_REFS: begin
                    r_st <= ST_OK; r_off <= r_soff[r_hs];
                    r_sref[r_hs] <= w_ref_new; r_refs <= w_ref_new;
                    r_fsize <= r_ssz[r_hs];
                    if (o_stat.freed) begin
                        r_sv[r_hs] <= 1'b0; r_freed <= 1'b1;
                        r_used <= r_used - r_ssz[r_hs];
                        r_live <= r_live - 1'b1;
                    end
                end
                CMD_REL_DEC: begin
                    r_wp <= (w_kind == 2'd1 && w_m2) ? r_rp : r_rcnt;
                    unique case (w_kind)
                        2'd1: begin
                            r_rsz[w_pm1] <= w_m2 ? r_rsz[w_pm1] + r_fsize + r_rsz[w_ri]
                                                 : r_rsz[w_pm1] + r_fsize;
                            if (w_m2) r_rcnt <= r_rcnt - 1'b1;
                        end
                        2'd2: begin
                            r_roff[w_ri] <= r_off;
                            r_rsz[w_ri] <= r_rsz[w_ri] + r_fsize;
                        end
                        default: ;
                    endcase
                end
                CMD_SHIFT_UP: begin
                    if (r_wp > r_rp) begin
                        r_roff[w_wi] <= r_roff[REG_W'(r_wp - 1'b1)];
                        r_rsz[w_wi]  <= r_rsz[REG_W'(r_wp - 1'b1)];
                    end
                    r_wp <= r_wp - 1'b1;
                end
                CMD_INSERT: begin
                    r_roff[w_ri] <= r_off; r_rsz[w_ri] <= r_fsize;
                    r_rcnt <= r_rcnt + 1'b1;
                end
                CMD_RESULT: begin
                    o_status       <= r_st;
                    o_new_id       <= (r_st == ST_OK && r_func == FN_CREATE)
                                      ? F_ID_W'(r_next_id - 1'b1) : 16'd0;
                    o_block_offset <= (r_st == ST_OK) ? r_off : '0;
                    o_ref_count    <= (r_st == ST_OK) ? r_refs : 16'd0;
                    o_freed        <= r_freed;
                    o_used_bytes   <= r_used;
                    o_live_blocks  <= F_LIVE_W'(r_live);
                end
                default: ;
            endcase
        end
    end
endmodule

[hdl/first_fit_refcount_allocator.sv]
// First-fit byte-pool allocator with reference counts and free-list merging.
// Unknown func, below minimum or ids exhausted go from accept straight to the result;
// create and increase/decrease walk the slot table and free list one step per cycle.
// One item at a time: the next item is accepted the cycle after a result loads, and a
// finished result waits in the result state while the output is stalled.
// Synchronous active-low reset: pool of 2^20 bytes, one free region, ids from 1.
module first_fit_refcount_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [20:0] i_alloc_size,
    input  logic [2:0]  i_type_code,
    input  logic [15:0] i_block_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_new_id,
    output logic [20:0] o_block_offset,
    output logic [15:0] o_ref_count,
    output logic        o_freed,
    output logic [20:0] o_used_bytes,
    output logic [4:0]  o_live_blocks
);
    import ffra_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    logic  w_busy, w_pre_fail, w_cfg_we, w_take;
    logic [FIELD_W-1:0] w_mem;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[1:0] == {REG_MEMORY_SIZE, 1'b0});
    assign prdata   = (paddr == {REG_MEMORY_SIZE, 1'b0}) ? {11'd0, w_mem} : 32'd0;
    assign o_stall  = w_busy;
    assign w_take   = o_valid && !i_stall;

    ffra_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(i_valid && !w_busy), .i_func, .i_pre_fail(w_pre_fail),
        .i_out_free(!o_valid || !i_stall), .i_stat(w_stat),
        .o_ctl(w_ctl), .o_busy(w_busy)
    );

    ffra_dp u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .o_stat(w_stat),
        .i_cfg_we(w_cfg_we), .i_cfg_data(pwdata[FIELD_W-1:0]), .o_mem_size(w_mem),
        .i_func, .i_alloc_size, .i_type_code, .i_block_id, .o_pre_fail(w_pre_fail),
        .i_out_take(w_take), .o_out_valid(o_valid),
        .o_status, .o_new_id, .o_block_offset, .o_ref_count, .o_freed,
        .o_used_bytes, .o_live_blocks
    );
endmodule

[hdl/ffra_checker.sv]
// Port-level checks for the allocator, attached by bind.
// Depends on ffra_pkg and the top-level ports.
module ffra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_new_id,
    input logic        o_freed,
    input logic [15:0] o_ref_count,
    input logic [4:0]  o_live_blocks
);
    import ffra_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("stalled item changed");
    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_live_blocks <= 5'd16)
        else $error("live count too large");
    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freed |-> o_ref_count == 16'd0 && o_status == ST_OK)
        else $error("freed with nonzero count");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_new_id == 16'd0 && o_ref_count == 16'd0)
        else $error("failed request carries data");
endmodule

bind first_fit_refcount_allocator ffra_checker u_chk (.*);
